[sv/dram_row_buffer_bank_timing_macros.svh]
// ----------------------------------------------------------------------------
// DRAM row buffer bank timing: assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DRAM_ROW_BUFFER_BANK_TIMING_MACROS_SVH
`define DRAM_ROW_BUFFER_BANK_TIMING_MACROS_SVH
`ifndef SYNTH
// Assertion checked outside reset.
`define DRBT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// Assertion checked at every clock edge, reset included.
`define DRBT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: assertion failed");
`else
`define DRBT_ASSERT(label, clk, rst_n, prop)
`define DRBT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[sv/drbt_pkg.sv]
// ----------------------------------------------------------------------------
// DRAM row buffer bank timing: package
// Shared types, defaults, codes and saturating time arithmetic.
// ----------------------------------------------------------------------------
package drbt_pkg;

  localparam int unsigned SEGMENTS_DEF  = 4;
  localparam int unsigned SUBBANKS_DEF  = 8;
  localparam int unsigned ROW_SLOTS_DEF = 4;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Event codes.
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_HOLD  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIT_DELAY      = 3'd0,
    REG_MISS_DELAY     = 3'd1,
    REG_ISSUE_INTERVAL = 3'd2,
    REG_PRECHARGE_TIME = 3'd3,
    REG_ROW_SIZE       = 3'd4,
    REG_OPEN_ROWS      = 3'd5,
    REG_PIPELINED      = 3'd6,
    REG_SHARING        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    action_e           action;
    logic [ADDR_W-1:0] address;
    logic [1:0]        segment_index;
    logic [2:0]        bank_index;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] hold_until;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] done_time;
    logic              row_hit;
    logic [TIME_W-1:0] wait_cycles;
  } out_item_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_HIT,
    ST_LATE,
    ST_LATE2,
    ST_START,
    ST_SUM1,
    ST_SUM2,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic ld_hit;
    logic ld_late;
    logic ld_late2;
    logic ld_start;
    logic ld_sum1;
    logic ld_sum2;
    logic commit;
    logic hold_commit;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_e action;
    logic    div_done;
  } status_t;

  // Saturating time sum.
  function automatic logic [TIME_W-1:0] tadd(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // Time difference clamped at zero.
  function automatic logic [TIME_W-1:0] tsub(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // Remainder of a small value by a small constant, by repeated subtraction.
  function automatic logic [3:0] small_mod(logic [3:0] v, logic [4:0] d);
    logic [3:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if ({1'b0, r} >= d) r = 4'({1'b0, r} - d);
    end
    return r;
  endfunction

endpackage

[sv/drbt_ram.sv]
// ----------------------------------------------------------------------------
// DRAM row buffer bank timing: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module drbt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/drbt_div.sv]
// ----------------------------------------------------------------------------
// DRAM row buffer bank timing: row number divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drbt_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [drbt_pkg::ADDR_W-1:0]     dividend_i,
  input  logic [drbt_pkg::CFG_DATA_W-1:0] divisor_i,
  output logic [drbt_pkg::ADDR_W-1:0]     quotient_o,
  output logic                            done_o
);
  import drbt_pkg::*;

  localparam int unsigned CNT_W = $clog2(ADDR_W + 1);

  logic [ADDR_W-1:0]     quo_q, quo_d;
  logic [CFG_DATA_W-1:0] rem_q, rem_d;
  logic [CFG_DATA_W-1:0] dvs_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CFG_DATA_W:0]   shifted;
  logic [CFG_DATA_W:0]   trial;

  // One restoring step.
  always_comb begin
    shifted = {rem_q, quo_q[ADDR_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = trial[CFG_DATA_W-1:0];
        quo_d = {quo_q[ADDR_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[CFG_DATA_W-1:0];
        quo_d = {quo_q[ADDR_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(ADDR_W);
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[sv/drbt_datapath.sv]
// ----------------------------------------------------------------------------
// DRAM row buffer bank timing: datapath
// Configuration, bank and segment timing state, row tags and result register.
// ----------------------------------------------------------------------------
module drbt_datapath #(
  parameter int unsigned SEGMENTS  = drbt_pkg::SEGMENTS_DEF,
  parameter int unsigned SUBBANKS  = drbt_pkg::SUBBANKS_DEF,
  parameter int unsigned ROW_SLOTS = drbt_pkg::ROW_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  drbt_pkg::in_item_t              in_data_i,
  input  logic                            cfg_we_i,
  input  logic [drbt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drbt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  drbt_pkg::cmd_t                  cmd_i,
  output drbt_pkg::status_t               status_o,
  output drbt_pkg::out_item_t             out_data_o
);
  import drbt_pkg::*;

  localparam int unsigned NBANKS = SEGMENTS * SUBBANKS;
  localparam int unsigned SEG_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned SUB_W  = (SUBBANKS > 1) ? $clog2(SUBBANKS) : 1;
  localparam int unsigned BANK_W = (NBANKS > 1) ? $clog2(NBANKS) : 1;
  localparam int unsigned SLOT_W = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
  localparam int unsigned BROW_W = 2 * TIME_W + SLOT_W;
  localparam int unsigned TROW_W = ROW_SLOTS * ADDR_W;

  // Configuration registers.
  logic [9:0]            hit_delay_q, miss_delay_q, precharge_time_q;
  logic [7:0]            issue_interval_q;
  logic [CFG_DATA_W-1:0] row_size_q;
  logic [2:0]            open_rows_q;
  logic                  pipelined_q, sharing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_delay_q      <= 10'd10;
      miss_delay_q     <= 10'd30;
      issue_interval_q <= 8'd2;
      precharge_time_q <= 10'd10;
      row_size_q       <= 17'd2048;
      open_rows_q      <= 3'd1;
      pipelined_q      <= 1'b0;
      sharing_q        <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_HIT_DELAY:      hit_delay_q      <= cfg_data_i[9:0];
        REG_MISS_DELAY:     miss_delay_q     <= cfg_data_i[9:0];
        REG_ISSUE_INTERVAL: issue_interval_q <= cfg_data_i[7:0];
        REG_PRECHARGE_TIME: precharge_time_q <= cfg_data_i[9:0];
        REG_ROW_SIZE:       row_size_q       <= cfg_data_i;
        REG_OPEN_ROWS:      open_rows_q      <= cfg_data_i[2:0];
        REG_PIPELINED:      pipelined_q      <= cfg_data_i[0];
        REG_SHARING:        sharing_q        <= cfg_data_i[0];
        default:            ;
      endcase
    end
  end

  // Derived configuration values.
  logic [CFG_DATA_W-1:0] row_div;
  logic [9:0]            diff;
  logic [3:0]            nrb;

  always_comb begin
    row_div = (row_size_q == '0) ? CFG_DATA_W'(1) : row_size_q;
    diff    = (miss_delay_q > hit_delay_q) ? (miss_delay_q - hit_delay_q) : '0;
    if (open_rows_q == 3'd0) begin
      nrb = 4'd1;
    end else if ({1'b0, open_rows_q} > 4'(ROW_SLOTS)) begin
      nrb = 4'(ROW_SLOTS);
    end else begin
      nrb = {1'b0, open_rows_q};
    end
  end

  // Index decode of the incoming item.
  logic [3:0]        seg_mod, bank_mod;
  logic [SEG_W-1:0]  seg_in;
  logic [SUB_W-1:0]  sub_in;
  logic [BANK_W-1:0] b_in;

  always_comb begin
    seg_mod = small_mod({2'b00, in_data_i.segment_index}, 5'(SEGMENTS));
    bank_mod = small_mod({1'b0, in_data_i.bank_index}, 5'(SUBBANKS));
    seg_in  = seg_mod[SEG_W-1:0];
    sub_in  = bank_mod[SUB_W-1:0];
    b_in    = BANK_W'(32'(seg_in) * SUBBANKS + 32'(sub_in));
  end

  // Item registers.
  in_item_t          item_q;
  logic [SEG_W-1:0]  seg_q;
  logic [SUB_W-1:0]  sub_q;
  logic [BANK_W-1:0] b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      seg_q  <= seg_in;
      sub_q  <= sub_in;
      b_q    <= b_in;
    end
  end

  // Row number divider.
  logic [ADDR_W-1:0] row;

  drbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (in_data_i.address),
    .divisor_i  (row_div),
    .quotient_o (row),
    .done_o     (status_o.div_done)
  );

  assign status_o.action = item_q.action;

  // Bank state memory: victim pointer, precharge ready and bank ready.
  logic              bank_we;
  logic [BROW_W-1:0] bank_wdata, bank_rdata, bank_rd;
  logic [NBANKS-1:0] bank_valid_q;

  drbt_ram #(.WIDTH(BROW_W), .DEPTH(NBANKS)) u_bank_ram (
    .clk_i   (clk_i),
    .we_i    (bank_we),
    .waddr_i (b_q),
    .wdata_i (bank_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (b_in),
    .rdata_o (bank_rdata)
  );

  // A bank never written reads as its reset value.
  assign bank_rd = bank_valid_q[b_q] ? bank_rdata : '0;

  logic [TIME_W-1:0] bank_ready_rd, prech_ready_rd;
  logic [SLOT_W-1:0] victim_rd;
  assign bank_ready_rd  = bank_rd[TIME_W-1:0];
  assign prech_ready_rd = bank_rd[2*TIME_W-1:TIME_W];
  assign victim_rd      = bank_rd[BROW_W-1:2*TIME_W];

  // Row tag memory, one row of slots per bank.
  logic              tag_we;
  logic [TROW_W-1:0] tag_wdata, tag_rdata;

  drbt_ram #(.WIDTH(TROW_W), .DEPTH(NBANKS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (b_q),
    .wdata_i (tag_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (b_in),
    .rdata_o (tag_rdata)
  );

  // Timing registers for one access.
  logic [ROW_SLOTS-1:0] row_valid_q [NBANKS];
  logic [TIME_W-1:0]    segment_ready_q [SEGMENTS];
  logic [TIME_W-1:0]    read_hold_q;
  logic                 hit_q;
  logic [TIME_W-1:0]    seg_rdy_q, start0_q, late_q, start_q, wait_q;
  logic [TIME_W-1:0]    t_miss_q, t_hit_q, t_iss_q, t_diff_q, t_prech_q, t_pipe_q;
  logic                 is_read, hit_read;
  logic                 hit_c;
  logic [TIME_W-1:0]    cand, late_c;

  assign is_read  = (item_q.action == ACT_READ);
  assign hit_read = is_read && hit_q;

  // Open row lookup over the slots in use.
  always_comb begin
    hit_c = 1'b0;
    for (int i = 0; i < ROW_SLOTS; i++) begin
      if ((4'(i) < nrb) && row_valid_q[b_q][i] &&
          (tag_rdata[i*ADDR_W +: ADDR_W] == row)) begin
        hit_c = 1'b1;
      end
    end
  end

  // Earliest start from segment and bank occupancy.
  always_comb begin
    cand   = hit_read ? seg_rdy_q : tsub(seg_rdy_q, TIME_W'(diff));
    late_c = seg_rdy_q;
    if (pipelined_q) begin
      late_c = (bank_ready_rd < cand) ? cand : bank_ready_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_hit) begin
      hit_q     <= hit_c;
      seg_rdy_q <= segment_ready_q[seg_q];
      start0_q  <= (is_read && (read_hold_q > item_q.now)) ? read_hold_q : item_q.now;
    end
    if (cmd_i.ld_late) begin
      late_q <= late_c;
    end
    if (cmd_i.ld_late2) begin
      if (!hit_read && (late_q < prech_ready_rd)) late_q <= prech_ready_rd;
    end
    if (cmd_i.ld_start) begin
      if (start0_q < late_q) begin
        start_q <= late_q;
        wait_q  <= is_read ? (late_q - start0_q) : '0;
      end else begin
        start_q <= start0_q;
        wait_q  <= '0;
      end
    end
    if (cmd_i.ld_sum1) begin
      t_miss_q <= tadd(start_q, TIME_W'(miss_delay_q));
      t_hit_q  <= tadd(start_q, TIME_W'(hit_delay_q));
      t_iss_q  <= tadd(start_q, TIME_W'(issue_interval_q));
      t_diff_q <= tadd(start_q, TIME_W'(diff));
    end
    if (cmd_i.ld_sum2) begin
      t_prech_q <= tadd(t_miss_q, TIME_W'(precharge_time_q));
      t_pipe_q  <= tadd(t_diff_q, TIME_W'(issue_interval_q));
    end
  end

  // Victim slot and new state values for the commit.
  logic [SLOT_W-1:0] victim_n, victim_next;
  logic [TIME_W-1:0] seg_new, bank_new, prech_new, done_c;
  logic              fill;

  always_comb begin
    fill        = !hit_read;
    victim_n    = (4'(victim_rd) >= nrb) ? '0 : victim_rd;
    victim_next = ((4'(victim_n) + 4'd1) >= nrb) ? '0 : SLOT_W'(victim_n + SLOT_W'(1));
    if (hit_read) begin
      seg_new   = pipelined_q ? t_iss_q : t_hit_q;
      bank_new  = pipelined_q ? t_iss_q : bank_ready_rd;
      prech_new = prech_ready_rd;
      done_c    = t_hit_q;
    end else begin
      seg_new   = pipelined_q ? t_pipe_q : t_miss_q;
      bank_new  = pipelined_q ? t_pipe_q : bank_ready_rd;
      prech_new = t_prech_q;
      done_c    = t_miss_q;
    end
    bank_wdata = {fill ? victim_next : victim_rd, prech_new, bank_new};
    tag_wdata  = tag_rdata;
    for (int i = 0; i < ROW_SLOTS; i++) begin
      if (SLOT_W'(i) == victim_n) tag_wdata[i*ADDR_W +: ADDR_W] = row;
    end
  end

  assign bank_we = cmd_i.commit;
  assign tag_we  = cmd_i.commit && fill;

  // Control state: bank valid flags, open row flags, segments and read hold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_valid_q <= '0;
      for (int i = 0; i < NBANKS; i++) row_valid_q[i] <= '0;
      for (int i = 0; i < SEGMENTS; i++) segment_ready_q[i] <= '0;
      read_hold_q <= '0;
    end else begin
      if (cmd_i.commit) begin
        bank_valid_q[b_q]     <= 1'b1;
        segment_ready_q[seg_q] <= seg_new;
        if (fill) begin
          row_valid_q[b_q][victim_n] <= 1'b1;
          if (sharing_q) begin
            if (sub_q != '0) row_valid_q[b_q - BANK_W'(1)][victim_n] <= 1'b0;
            if (32'(sub_q) + 1 < SUBBANKS) row_valid_q[b_q + BANK_W'(1)][victim_n] <= 1'b0;
          end
        end
      end
      if (cmd_i.hold_commit && (read_hold_q < item_q.hold_until)) begin
        read_hold_q <= item_q.hold_until;
      end
    end
  end

  // Result of the access and the output register.
  logic [TIME_W-1:0] done_q;
  out_item_t         out_q;
  logic              access;

  assign access = (item_q.action == ACT_READ) || (item_q.action == ACT_WRITE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      done_q <= done_c;
    end
    if (cmd_i.out_load) begin
      if (access) begin
        out_q.done_time   <= done_q;
        out_q.row_hit     <= hit_q;
        out_q.wait_cycles <= wait_q;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

[sv/drbt_ctrl.sv]
// ----------------------------------------------------------------------------
// DRAM row buffer bank timing: controller
// Sequences one event through division and, for a read or write, timing steps and commit.
// ----------------------------------------------------------------------------
module drbt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  drbt_pkg::status_t status_i,
  output drbt_pkg::cmd_t    cmd_o
);
  import drbt_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   access;

  assign access = (status_i.action == ACT_READ) || (status_i.action == ACT_WRITE);

  // State register and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          if (access) begin
            cmd_o.ld_hit = 1'b1;
            state_d      = ST_HIT;
          end else begin
            cmd_o.hold_commit = (status_i.action == ACT_HOLD);
            state_d           = ST_FINISH;
          end
        end
      end
      ST_HIT: begin
        cmd_o.ld_late = 1'b1;
        state_d       = ST_LATE;
      end
      ST_LATE: begin
        cmd_o.ld_late2 = 1'b1;
        state_d        = ST_LATE2;
      end
      ST_LATE2: begin
        cmd_o.ld_start = 1'b1;
        state_d        = ST_START;
      end
      ST_START: begin
        cmd_o.ld_sum1 = 1'b1;
        state_d       = ST_SUM1;
      end
      ST_SUM1: begin
        cmd_o.ld_sum2 = 1'b1;
        state_d       = ST_SUM2;
      end
      ST_SUM2: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_COMMIT;
      end
      ST_COMMIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/dram_row_buffer_bank_timing.sv]
// ----------------------------------------------------------------------------
// DRAM row buffer bank timing
// Open row buffer and bank timing model for DRAM read, write and hold events.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  in_data_i  (in_item_t)
//   out      output     out_valid_o/out_ready_i out_data_o (out_item_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A read or write passes through the row number divider, the timing steps and the
// commit before its result is loaded; a hold or an unused action skips the timing steps.
// One event is in work at a time; the next is taken while a result waits.
// Reset clears all timing state and closes all rows at once; no sweep follows.
// A stalled output holds the finished event until the result is taken.
// ----------------------------------------------------------------------------
`include "dram_row_buffer_bank_timing_macros.svh"

module dram_row_buffer_bank_timing #(
  parameter int unsigned SEGMENTS  = drbt_pkg::SEGMENTS_DEF,
  parameter int unsigned SUBBANKS  = drbt_pkg::SUBBANKS_DEF,
  parameter int unsigned ROW_SLOTS = drbt_pkg::ROW_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  drbt_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output drbt_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [drbt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [drbt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import drbt_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  drbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  drbt_datapath #(
    .SEGMENTS  (SEGMENTS),
    .SUBBANKS  (SUBBANKS),
    .ROW_SLOTS (ROW_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

  // An accepted event blocks the input until it is finished.
  `DRBT_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // Loading the result raises the output valid flag.
  `DRBT_ASSERT(a_load_sets_valid, clk_i, rst_ni, cmd.out_load |=> out_valid_o)
  // A new result appears only as the controller returns to accept input.
  `DRBT_ASSERT(a_rise_with_ready, clk_i, rst_ni, $rose(out_valid_o) |-> in_ready_o)
  // No result is offered while reset is applied.
  `DRBT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o)

endmodule

[test/tb_dram_row_buffer_bank_timing.sv]
// ----------------------------------------------------------------------------
// DRAM row buffer bank timing testbench
// Drives read, write, hold and unused events through the valid/ready input channel,
// predicts every result with an independent model of the bank timing and
// compares each output transfer field by field. Several register settings
// are visited, with random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dram_row_buffer_bank_timing;
  import drbt_pkg::*;

  localparam int NSEG   = 4;
  localparam int NSUB   = 8;
  localparam int NSLOT  = 4;
  localparam int NBANK  = NSEG * NSUB;
  localparam int LIMIT  = 2000000;
  localparam int DRAIN  = 100;
  localparam int STALL_LEN = 400;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b1;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  dram_row_buffer_bank_timing DUT (.*);

  // Clock generation.
  always #10 clk_i = ~clk_i;

  // Predictor state and register copies.
  logic [9:0]  hit_dly, miss_dly, pre_time;
  logic [7:0]  issue_int;
  logic [16:0] row_sz;
  logic [2:0]  rows_cfg;
  logic        pipe_mode, share_mode;
  logic [TIME_W-1:0] seg_rdy [NSEG];
  logic [TIME_W-1:0] bank_rdy [NBANK];
  logic [TIME_W-1:0] pre_rdy [NBANK];
  logic [1:0]        victim [NBANK];
  logic [31:0]       tag [NBANK*NSLOT];
  logic              tag_ok [NBANK*NSLOT];
  logic [TIME_W-1:0] hold_time;

  in_item_t  pending_events[$];
  out_item_t expected_results[$];
  int  errors = 0;
  int  cycles = 0;
  int  snd_idle = 22, rcv_idle = 79;
  int  stall_cnt = 0;
  bit  stall_go = 1'b0;
  bit  stall_done = 1'b0;
  bit  in_taken = 1'b0;
  bit  stim_done = 1'b0;

  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a,
                                                logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] clamp_sub(logic [TIME_W-1:0] a,
                                                  logic [TIME_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Miss or write timing; returns the completion time.
  function automatic logic [TIME_W-1:0] miss_timing(int s, int b, logic [TIME_W-1:0] st);
    logic [TIME_W-1:0] gap, t;
    gap = clamp_sub(miss_dly, hit_dly);
    pre_rdy[b] = sat_add(sat_add(st, miss_dly), pre_time);
    if (pipe_mode) begin
      t = sat_add(sat_add(st, gap), issue_int);
      seg_rdy[s] = t;
      bank_rdy[b] = t;
    end else begin
      seg_rdy[s] = sat_add(st, miss_dly);
    end
    return sat_add(st, miss_dly);
  endfunction

  // Opens a row in the bank, round-robin over the slots in use.
  function automatic void open_row(int s, int k, logic [31:0] row, int nrb);
    int b, n;
    b = s * NSUB + k;
    n = (victim[b] >= nrb) ? 0 : victim[b];
    tag[b*NSLOT+n] = row;
    tag_ok[b*NSLOT+n] = 1'b1;
    victim[b] = (n + 1 >= nrb) ? 2'd0 : 2'(n + 1);
    if (share_mode) begin
      if (k != 0) tag_ok[(b-1)*NSLOT+n] = 1'b0;
      if (k + 1 < NSUB) tag_ok[(b+1)*NSLOT+n] = 1'b0;
    end
  endfunction

  // Computes the result of one event and updates the bank state.
  function automatic out_item_t bank_access(in_item_t ev);
    out_item_t r;
    int s, k, b, nrb;
    logic [31:0] row;
    logic [TIME_W-1:0] gap, late, st, cand;
    logic hit;
    r = '0;
    s = ev.segment_index % NSEG;
    k = ev.bank_index % NSUB;
    b = s * NSUB + k;
    gap = clamp_sub(miss_dly, hit_dly);
    row = ev.address / ((row_sz == 0) ? 32'd1 : 32'(row_sz));
    nrb = (rows_cfg == 0) ? 1 : (rows_cfg > NSLOT) ? NSLOT : rows_cfg;
    hit = 1'b0;
    if (ev.action == ACT_HOLD) begin
      if (hold_time < ev.hold_until) hold_time = ev.hold_until;
      return r;
    end
    if (ev.action == ACT_NOP) return r;
    for (int i = 0; i < nrb; i++)
      if (tag_ok[b*NSLOT+i] && tag[b*NSLOT+i] == row) hit = 1'b1;
    r.row_hit = hit;
    if (ev.action == ACT_READ) begin
      st = (ev.now > hold_time) ? ev.now : hold_time;
      if (pipe_mode) begin
        cand = hit ? seg_rdy[s] : clamp_sub(seg_rdy[s], gap);
        late = (bank_rdy[b] < cand) ? cand : bank_rdy[b];
      end else begin
        late = seg_rdy[s];
      end
      if (!hit && late < pre_rdy[b]) late = pre_rdy[b];
      if (st < late) begin
        r.wait_cycles = late - st;
        st = late;
      end
      if (hit) begin
        if (pipe_mode) begin
          seg_rdy[s] = sat_add(st, issue_int);
          bank_rdy[b] = seg_rdy[s];
        end else begin
          seg_rdy[s] = sat_add(st, hit_dly);
        end
        r.done_time = sat_add(st, hit_dly);
      end else begin
        r.done_time = miss_timing(s, b, st);
        open_row(s, k, row, nrb);
      end
    end else begin
      if (pipe_mode) begin
        cand = clamp_sub(seg_rdy[s], gap);
        late = (bank_rdy[b] < cand) ? cand : bank_rdy[b];
      end else begin
        late = seg_rdy[s];
      end
      if (late < pre_rdy[b]) late = pre_rdy[b];
      st = (ev.now > late) ? ev.now : late;
      r.done_time = miss_timing(s, b, st);
      open_row(s, k, row, nrb);
    end
    return r;
  endfunction

  // Register write, applied to the predictor at the same transfer.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_HIT_DELAY:      hit_dly = val[9:0];
      REG_MISS_DELAY:     miss_dly = val[9:0];
      REG_ISSUE_INTERVAL: issue_int = val[7:0];
      REG_PRECHARGE_TIME: pre_time = val[9:0];
      REG_ROW_SIZE:       row_sz = val;
      REG_OPEN_ROWS:      rows_cfg = val[2:0];
      REG_PIPELINED:      pipe_mode = val[0];
      REG_SHARING:        share_mode = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits for the queue and the block to drain before a register write.
  task automatic wait_idle();
    while (pending_events.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_event(logic [TIME_W-1:0] base);
    in_item_t ev;
    int p;
    p = $urandom_range(99);
    ev.action = (p < 45) ? ACT_READ : (p < 80) ? ACT_WRITE : (p < 95) ? ACT_HOLD : ACT_NOP;
    // Few distinct rows so that hits are common.
    ev.address = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(7)) << 12;
    ev.segment_index = $urandom();
    ev.bank_index = $urandom();
    ev.now = ($urandom_range(49) == 0) ? {$urandom(), $urandom()}
                                       : base + $urandom_range(200);
    ev.hold_until = ($urandom_range(9) == 0) ? {$urandom(), $urandom()}
                                             : base + $urandom_range(300);
    return ev;
  endfunction

  task automatic random_phase(int n);
    logic [TIME_W-1:0] base;
    base = $urandom_range(1000);
    for (int i = 0; i < n; i++) begin
      pending_events.push_back(rand_event(base));
      base += $urandom_range(60);
    end
  endtask

  // Stimulus and register phases.
  initial begin
    in_item_t ev;
    rst_ni <= 1'b0;
    hit_dly = 10; miss_dly = 30; issue_int = 2; pre_time = 10;
    row_sz = 2048; rows_cfg = 1; pipe_mode = 0; share_mode = 0;
    foreach (seg_rdy[i]) seg_rdy[i] = '0;
    for (int i = 0; i < NBANK; i++) begin
      bank_rdy[i] = '0; pre_rdy[i] = '0; victim[i] = '0;
    end
    for (int i = 0; i < NBANK*NSLOT; i++) begin
      tag[i] = '0; tag_ok[i] = 1'b0;
    end
    hold_time = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed events: every action, field extremes, saturation and holds.
    ev = '0;
    ev.action = ACT_READ;  pending_events.push_back(ev);
    pending_events.push_back(ev);
    ev.action = ACT_WRITE; ev.address = '1; ev.segment_index = 2'd3;
    ev.bank_index = 3'd7; ev.now = 48'd100; pending_events.push_back(ev);
    ev.action = ACT_READ;  pending_events.push_back(ev);
    ev.now = '1; pending_events.push_back(ev);
    ev.action = ACT_HOLD;  ev.hold_until = 48'd5000; pending_events.push_back(ev);
    ev.hold_until = 48'd10; pending_events.push_back(ev);
    ev.action = ACT_READ;  ev.now = 48'd20; ev.address = 32'd4096;
    ev.bank_index = 3'd0; ev.segment_index = 2'd0; pending_events.push_back(ev);
    ev.action = ACT_NOP;   ev.hold_until = '1; ev.address = '1; pending_events.push_back(ev);
    ev.action = ACT_HOLD;  pending_events.push_back(ev);
    ev.action = ACT_WRITE; ev.now = 48'hFFFF_FFFF_FF00; pending_events.push_back(ev);
    wait_idle();
    // Pipelined, sharing, several open rows, extreme delays, tiny rows.
    write_reg(REG_PIPELINED, 1);
    write_reg(REG_SHARING, 1);
    write_reg(REG_OPEN_ROWS, 4);
    write_reg(REG_ROW_SIZE, 1);
    write_reg(REG_HIT_DELAY, 1023);
    write_reg(REG_MISS_DELAY, 1);
    write_reg(REG_ISSUE_INTERVAL, 255);
    write_reg(REG_PRECHARGE_TIME, 0);
    for (int k = 0; k < 8; k++) begin
      ev = '0; ev.action = (k % 2) ? ACT_READ : ACT_WRITE;
      ev.address = k / 2; ev.bank_index = 3'(k % 3); ev.now = 48'(k * 3);
      pending_events.push_back(ev);
    end
    random_phase(120);
    wait_idle();
    write_reg(REG_HIT_DELAY, 1);
    write_reg(REG_MISS_DELAY, 1023);
    write_reg(REG_ISSUE_INTERVAL, 0);
    write_reg(REG_PRECHARGE_TIME, 1023);
    write_reg(REG_ROW_SIZE, 17'h10000);
    write_reg(REG_OPEN_ROWS, 0);
    write_reg(REG_SHARING, 0);
    random_phase(120);
    wait_idle();
    snd_idle = 79; rcv_idle = 22;
    write_reg(REG_ROW_SIZE, 0);
    write_reg(REG_OPEN_ROWS, 7);
    write_reg(REG_PIPELINED, 0);
    write_reg(REG_SHARING, 1);
    write_reg(REG_HIT_DELAY, 10);
    write_reg(REG_MISS_DELAY, 30);
    random_phase(130);
    wait_idle();
    snd_idle = 0; rcv_idle = 0;
    write_reg(REG_ROW_SIZE, 4096);
    write_reg(REG_OPEN_ROWS, 2);
    write_reg(REG_PIPELINED, 1);
    write_reg(REG_ISSUE_INTERVAL, 3);
    write_reg(REG_PRECHARGE_TIME, 10);
    stall_go = 1'b1;
    random_phase(130);
    stim_done = 1'b1;
  end

  // Driver: offers the oldest pending event, holding it until transfer.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= snd_idle) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_events[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random idling, and one long stall once requested.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_go && !stall_done) begin
        out_ready_i <= 1'b0;
        if (stall_cnt == STALL_LEN - 1) stall_done <= 1'b1;
        stall_cnt <= stall_cnt + 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Monitor: predicts on input transfers, checks output transfers.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(bank_access(in_data_i));
        void'(pending_events.pop_front());
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data_o.done_time !== exp_r.done_time) begin
            errors++;
            $display("%0t: done_time expected %0d actual %0d", $time,
                     exp_r.done_time, out_data_o.done_time);
          end
          if (out_data_o.row_hit !== exp_r.row_hit) begin
            errors++;
            $display("%0t: row_hit expected %0d actual %0d", $time,
                     exp_r.row_hit, out_data_o.row_hit);
          end
          if (out_data_o.wait_cycles !== exp_r.wait_cycles) begin
            errors++;
            $display("%0t: wait_cycles expected %0d actual %0d", $time,
                     exp_r.wait_cycles, out_data_o.wait_cycles);
          end
        end
      end
    end
  end

  // End of run and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
